// File: rtl/lsbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types and constants of the lsb-first bit packer: request and result
// structs, command codes, register indexes and the width configuration group.
// ----------------------------------------------------------------------------
package lsbp_pkg;

    // field widths
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int FWIDTH_W = 6;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 3;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int REG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TYPE_ONE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TYPE_TWO   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TYPE_THREE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TYPE_FOUR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EXPLICIT   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CHAR       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BIT        = 3'd6;
    localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd7;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_ONE   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_TWO   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_THREE = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH_FOUR  = 2'd3;

    // fixed widths
    localparam logic [FWIDTH_W-1:0] WIDTH_RESET = 6'd8;
    localparam logic [FWIDTH_W-1:0] WIDTH_CHAR  = 6'd7;
    localparam logic [FWIDTH_W-1:0] WIDTH_BIT   = 6'd1;
    localparam logic [VALUE_W-1:0]  CHAR_MASK   = 32'h0000_007f;
    localparam logic [VALUE_W-1:0]  BIT_MASK    = 32'h0000_0001;

    // input request
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [VALUE_W-1:0]  field_value;
        logic [FWIDTH_W-1:0] field_width;
    } t_in_item;

    // output result byte
    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_of_run;
    } t_out_item;

    // configured type widths
    typedef struct packed {
        logic [FWIDTH_W-1:0] width_type_one;
        logic [FWIDTH_W-1:0] width_type_two;
        logic [FWIDTH_W-1:0] width_type_three;
        logic [FWIDTH_W-1:0] width_type_four;
    } t_cfg;

endpackage

// File: rtl/lsbp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbp_cfg
// APB-style register file holding the four configured type widths.
// ----------------------------------------------------------------------------
module lsbp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsbp_pkg::APB_AW-1:0]  paddr,
    input  logic [lsbp_pkg::APB_DW-1:0]  pwdata,
    output logic [lsbp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output lsbp_pkg::t_cfg               o_cfg
);

    logic                                 wr_en;
    logic [lsbp_pkg::REG_IDX_W-1:0]       reg_idx;
    logic [lsbp_pkg::FWIDTH_W-1:0]        wr_val;
    logic [lsbp_pkg::FWIDTH_W-1:0]        rd_val;
    lsbp_pkg::t_cfg                       r_cfg;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[lsbp_pkg::APB_AW-1:2];
    assign wr_val  = pwdata[lsbp_pkg::FWIDTH_W-1:0];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_type_one   <= lsbp_pkg::WIDTH_RESET;
            r_cfg.width_type_two   <= lsbp_pkg::WIDTH_RESET;
            r_cfg.width_type_three <= lsbp_pkg::WIDTH_RESET;
            r_cfg.width_type_four  <= lsbp_pkg::WIDTH_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                lsbp_pkg::REG_WIDTH_ONE:   r_cfg.width_type_one   <= wr_val;
                lsbp_pkg::REG_WIDTH_TWO:   r_cfg.width_type_two   <= wr_val;
                lsbp_pkg::REG_WIDTH_THREE: r_cfg.width_type_three <= wr_val;
                lsbp_pkg::REG_WIDTH_FOUR:  r_cfg.width_type_four  <= wr_val;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            lsbp_pkg::REG_WIDTH_ONE:   rd_val = r_cfg.width_type_one;
            lsbp_pkg::REG_WIDTH_TWO:   rd_val = r_cfg.width_type_two;
            lsbp_pkg::REG_WIDTH_THREE: rd_val = r_cfg.width_type_three;
            lsbp_pkg::REG_WIDTH_FOUR:  rd_val = r_cfg.width_type_four;
            default:                   rd_val = '0;
        endcase
    end

    assign prdata = {{(lsbp_pkg::APB_DW - lsbp_pkg::FWIDTH_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

// File: rtl/lsbp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbp_core
// Sequencer and shared chunk unit: each step moves up to one byte's worth of
// field bits into the partial byte and emits it once full.
// ----------------------------------------------------------------------------
module lsbp_core #(
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsbp_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lsbp_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lsbp_pkg::t_out_item  o_out
);

    localparam int RW = $clog2(MAX_FIELD_WIDTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    t_state                          r_state;
    logic [lsbp_pkg::VALUE_W-1:0]    r_val;
    logic [RW-1:0]                   r_rem;
    logic [lsbp_pkg::BYTE_W-1:0]     r_part;
    logic [lsbp_pkg::POS_W-1:0]      r_pos;
    logic                            r_out_valid;
    lsbp_pkg::t_out_item             r_out;

    logic                            accept;
    logic                            slot_free;
    logic [lsbp_pkg::FWIDTH_W-1:0]   raw_width;
    logic [RW-1:0]                   load_width;
    logic [lsbp_pkg::VALUE_W-1:0]    load_val;
    logic [3:0]                      space;
    logic [3:0]                      take;
    logic [lsbp_pkg::BYTE_W:0]       mask_wide;
    logic [lsbp_pkg::BYTE_W-1:0]     chunk;
    logic [lsbp_pkg::BYTE_W-1:0]     merged;
    logic [3:0]                      pos_sum;
    logic [RW-1:0]                   rem_next;
    logic                            last;
    logic                            emit;
    logic                            n_out_valid;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign slot_free  = ~r_out_valid | i_out_ready;

    // width and value of a new request
    always_comb begin
        unique case (i_in.cmd)
            lsbp_pkg::CMD_TYPE_ONE:   raw_width = i_cfg.width_type_one;
            lsbp_pkg::CMD_TYPE_TWO:   raw_width = i_cfg.width_type_two;
            lsbp_pkg::CMD_TYPE_THREE: raw_width = i_cfg.width_type_three;
            lsbp_pkg::CMD_TYPE_FOUR:  raw_width = i_cfg.width_type_four;
            lsbp_pkg::CMD_EXPLICIT:   raw_width = i_in.field_width;
            lsbp_pkg::CMD_CHAR:       raw_width = lsbp_pkg::WIDTH_CHAR;
            lsbp_pkg::CMD_BIT:        raw_width = lsbp_pkg::WIDTH_BIT;
            default:                  raw_width = '0;
        endcase
        case (i_in.cmd)
            lsbp_pkg::CMD_CHAR: load_val = i_in.field_value & lsbp_pkg::CHAR_MASK;
            lsbp_pkg::CMD_BIT:  load_val = i_in.field_value & lsbp_pkg::BIT_MASK;
            default:            load_val = i_in.field_value;
        endcase
        // saturate to the largest supported width
        if (int'(raw_width) > MAX_FIELD_WIDTH) begin
            load_width = RW'(MAX_FIELD_WIDTH);
        end else begin
            load_width = RW'(raw_width);
        end
    end

    // shared chunk unit: one step of up to eight bits
    always_comb begin
        space     = 4'd8 - {1'b0, r_pos};
        take      = (r_rem < RW'(space)) ? 4'(r_rem) : space;
        mask_wide = (9'd1 << take) - 9'd1;
        chunk     = r_val[lsbp_pkg::BYTE_W-1:0] & mask_wide[lsbp_pkg::BYTE_W-1:0];
        merged    = r_part | (chunk << r_pos);
        pos_sum   = {1'b0, r_pos} + take;
        rem_next  = r_rem - RW'(take);
        last      = (rem_next < RW'(8));
    end

    // a byte enters the output register this cycle
    assign emit        = slot_free & (((r_state == ST_RUN) & pos_sum[3]) |
                                      (r_state == ST_FLUSH));
    assign n_out_valid = emit | (r_out_valid & ~i_out_ready);

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_part      <= '0;
            r_pos       <= '0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_val <= load_val;
                        r_rem <= load_width;
                        if (i_in.cmd == lsbp_pkg::CMD_FLUSH) begin
                            if (r_pos != '0) begin
                                r_state <= ST_FLUSH;
                            end
                        end else if (load_width != '0) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (slot_free) begin
                        r_val <= r_val >> take;
                        r_rem <= rem_next;
                        if (pos_sum[3]) begin
                            r_out.packed_byte <= merged;
                            r_out.last_of_run <= last;
                            r_part            <= '0;
                            r_pos             <= '0;
                        end else begin
                            r_part <= merged;
                            r_pos  <= pos_sum[lsbp_pkg::POS_W-1:0];
                        end
                        if (rem_next == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (slot_free) begin
                        r_out.packed_byte <= r_part;
                        r_out.last_of_run <= 1'b1;
                        r_part            <= '0;
                        r_pos             <= '0;
                        r_state           <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/lsb_first_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Variable-width bit packer, least significant bit first, with flush.
// ----------------------------------------------------------------------------
// Each request appends a field of 0 to MAX_FIELD_WIDTH bits to a byte stream,
// low bit first, and every byte that fills is sent out with last_of_run set on
// the final byte of that request; a flush sends a non-empty partial byte and
// clears it. Requests go through one shared chunk unit that moves at most one
// byte's worth of bits per cycle while the output register can take a byte; a
// request is accepted and then worked off in steps, and no new request is
// taken until the current one is done. Width registers sit at byte addresses
// 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer #(
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lsbp_pkg::APB_AW-1:0]  paddr,
    input  logic [lsbp_pkg::APB_DW-1:0]  pwdata,
    output logic [lsbp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  lsbp_pkg::t_in_item           i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output lsbp_pkg::t_out_item          o_out
);

    lsbp_pkg::t_cfg cfg;

    // configuration registers
    lsbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // packing sequencer
    lsbp_core #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: test/lsbp_byte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbp_byte_checker
// Watches the request, result and register ports of the lsb-first bit packer,
// keeps its own copy of the width registers, the partial byte and the bit
// position, works out the bytes each request must produce and compares every
// accepted result with the oldest byte still expected.
// ----------------------------------------------------------------------------
module lsbp_byte_checker
    import lsbp_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                pready,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  t_in_item            i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  t_out_item           i_out,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_requests,
    output int                  o_results
);

    // shadow copy of the block state
    t_cfg              shadow_widths;
    logic [BYTE_W-1:0] shadow_byte;
    logic [POS_W-1:0]  shadow_pos;
    t_out_item         expected_bytes[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_requests   = 0;
        o_results    = 0;
    end

    // one line per mismatch, output capped so a broken block keeps the log short
    task automatic report_mismatch(input string msg);
        if (o_fail_count < 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end else if (o_fail_count == 40) begin
            $display("[%0t] further mismatches counted but not shown", $realtime);
        end
        o_fail_count++;
    endtask

    // append one request to the shadow byte and queue the bytes it completes
    function automatic void pack_request(input t_in_item req);
        logic [6:0]        width;
        logic [63:0]       bits;
        logic [BYTE_W-1:0] done_bytes[0:15];
        int                n_done;
        t_out_item         res;

        n_done = 0;
        width  = '0;
        bits   = {32'b0, req.field_value};
        case (req.cmd)
            CMD_TYPE_ONE:   width = {1'b0, shadow_widths.width_type_one};
            CMD_TYPE_TWO:   width = {1'b0, shadow_widths.width_type_two};
            CMD_TYPE_THREE: width = {1'b0, shadow_widths.width_type_three};
            CMD_TYPE_FOUR:  width = {1'b0, shadow_widths.width_type_four};
            CMD_EXPLICIT:   width = {1'b0, req.field_width};
            CMD_CHAR: begin
                width = {1'b0, WIDTH_CHAR};
                bits  = bits & {32'b0, CHAR_MASK};
            end
            CMD_BIT: begin
                width = {1'b0, WIDTH_BIT};
                bits  = bits & {32'b0, BIT_MASK};
            end
            default: width = '0;
        endcase

        if (req.cmd == CMD_FLUSH) begin
            // a flush sends the partial byte only when it holds bits
            if (shadow_pos != '0) begin
                done_bytes[0] = shadow_byte;
                n_done = 1;
            end
            shadow_byte = '0;
            shadow_pos  = '0;
        end else begin
            // oversize widths saturate, bits past bit 31 read as zero
            if (width > 7'(MAX_FIELD_WIDTH)) width = 7'(MAX_FIELD_WIDTH);
            for (int i = 0; i < int'(width); i++) begin
                shadow_byte[shadow_pos] = bits[i];
                if (shadow_pos == 3'd7) begin
                    done_bytes[n_done] = shadow_byte;
                    n_done++;
                    shadow_byte = '0;
                    shadow_pos  = '0;
                end else begin
                    shadow_pos = shadow_pos + 3'd1;
                end
            end
        end

        for (int k = 0; k < n_done; k++) begin
            res.packed_byte = done_bytes[k];
            res.last_of_run = (k == n_done - 1);
            expected_bytes.insert(expected_bytes.size(), res);
        end
    endfunction

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shadow_widths = '{WIDTH_RESET, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET};
            shadow_byte   = '0;
            shadow_pos    = '0;
            expected_bytes.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_WIDTH_ONE:   shadow_widths.width_type_one   = pwdata[FWIDTH_W-1:0];
                    REG_WIDTH_TWO:   shadow_widths.width_type_two   = pwdata[FWIDTH_W-1:0];
                    REG_WIDTH_THREE: shadow_widths.width_type_three = pwdata[FWIDTH_W-1:0];
                    REG_WIDTH_FOUR:  shadow_widths.width_type_four  = pwdata[FWIDTH_W-1:0];
                    default: ;
                endcase
            end

            // results are checked before this edge's request adds new bytes
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("result %0d byte %02h with nothing expected",
                                              o_results, i_out.packed_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.packed_byte !== want.packed_byte) begin
                        report_mismatch($sformatf("result %0d packed_byte %02h, expected %02h",
                                                  o_results, i_out.packed_byte,
                                                  want.packed_byte));
                    end
                    if (i_out.last_of_run !== want.last_of_run) begin
                        report_mismatch($sformatf("result %0d last_of_run %0b, expected %0b",
                                                  o_results, i_out.last_of_run,
                                                  want.last_of_run));
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                o_requests++;
                pack_request(i_in);
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

// File: test/lsb_first_bit_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_tb
// Drives the lsb-first bit packer with a directed set of requests (width
// extremes, every command, saturation, flushes of empty and partial bytes)
// and then with random phases under different width settings and random
// idle patterns on both sides; lsbp_byte_checker predicts and compares.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_tb;
    import lsbp_pkg::*;

    localparam int MAX_FIELD_WIDTH = 32;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int N_PHASES        = 6;
    localparam int PHASE_REQUESTS  = 68;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [APB_AW-1:0]  paddr       = '0;
    logic [APB_DW-1:0]  pwdata      = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in        = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out;

    int fail_count;
    int pending;
    int n_requests;
    int n_results;
    int n_settings  = 1;
    bit tx_idle     = 1'b0;
    bit rx_idle     = 1'b0;
    int rx_hold     = 0;
    int rx_pause;
    int idle_cycles = 0;

    lsb_first_bit_packer #(
        .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    lsbp_byte_checker #(
        .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out       (o_out),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_requests  (n_requests),
        .o_results   (n_results)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side: after each accepted byte, when rx_idle is set, drop ready for a random pause
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_hold     <= 0;
        end else if (i_out_ready && o_out_valid) begin
            rx_pause = rx_idle ? $urandom_range(0, 7) : 0;
            rx_hold     <= rx_pause;
            i_out_ready <= (rx_pause == 0);
        end else if (rx_hold > 0) begin
            rx_hold     <= rx_hold - 1;
            i_out_ready <= (rx_hold == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without progress", IDLE_LIMIT);
            $display("lsb_first_bit_packer test failed");
            $finish;
        end
    end

    // register write: setup cycle, then access until pready
    task automatic write_width(input logic [REG_IDX_W-1:0] idx, input logic [5:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all_widths(input logic [5:0] w1, input logic [5:0] w2,
                                    input logic [5:0] w3, input logic [5:0] w4);
        write_width(REG_WIDTH_ONE, w1);
        write_width(REG_WIDTH_TWO, w2);
        write_width(REG_WIDTH_THREE, w3);
        write_width(REG_WIDTH_FOUR, w4);
        n_settings++;
    endtask

    // one request: optional gap, then hold valid until accepted
    task automatic send_request(input t_in_item req);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                            input logic [FWIDTH_W-1:0] width);
        t_in_item req;
        req.cmd         = cmd;
        req.field_value = value;
        req.field_width = width;
        send_request(req);
    endtask

    // stop sending, let every expected byte arrive, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_width();
        case ($urandom_range(0, 5))
            0:       return 6'd0;
            1:       return 6'd32;
            2:       return 6'($urandom_range(33, 63));
            3:       return 6'd8;
            default: return 6'($urandom_range(0, 32));
        endcase
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        req.cmd = CMD_W'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0:       req.field_value = '0;
            1:       req.field_value = '1;
            default: req.field_value = $urandom();
        endcase
        if ($urandom_range(0, 9) == 0) begin
            req.field_width = FWIDTH_W'($urandom_range(33, 63));
        end else begin
            req.field_width = FWIDTH_W'($urandom_range(0, 32));
        end
        return req;
    endfunction

    // stimulus
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset widths of 8, no idling
        send_cmd(CMD_TYPE_ONE,   32'hffff_ffff, 6'd0);
        send_cmd(CMD_TYPE_TWO,   32'h0000_0000, 6'd63);
        send_cmd(CMD_BIT,        32'hffff_ffff, 6'd0);
        send_cmd(CMD_BIT,        32'hffff_fffe, 6'd0);
        send_cmd(CMD_CHAR,       32'hffff_ffff, 6'd0);
        send_cmd(CMD_FLUSH,      32'hffff_ffff, 6'd63);
        send_cmd(CMD_FLUSH,      32'h0000_0000, 6'd0);
        send_cmd(CMD_EXPLICIT,   32'hffff_ffff, 6'd0);
        send_cmd(CMD_EXPLICIT,   32'hffff_ffff, 6'd32);
        send_cmd(CMD_EXPLICIT,   32'ha5a5_a5a5, 6'd63);
        send_cmd(CMD_BIT,        32'h0000_0001, 6'd0);
        send_cmd(CMD_EXPLICIT,   32'h8000_0001, 6'd33);
        send_cmd(CMD_TYPE_THREE, 32'h0000_005a, 6'd0);
        send_cmd(CMD_TYPE_FOUR,  32'h0000_00c3, 6'd0);
        send_cmd(CMD_FLUSH,      32'h0000_0000, 6'd0);
        drain_results();

        // width extremes: empty, full, saturated, single bit
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        write_all_widths(6'd0, 6'd32, 6'd63, 6'd1);
        send_cmd(CMD_TYPE_ONE,   32'hffff_ffff, 6'd0);
        send_cmd(CMD_TYPE_TWO,   32'hdead_beef, 6'd0);
        send_cmd(CMD_TYPE_THREE, 32'h1234_5678, 6'd0);
        send_cmd(CMD_TYPE_FOUR,  32'h0000_0001, 6'd0);
        send_cmd(CMD_TYPE_FOUR,  32'hffff_fffe, 6'd0);
        send_cmd(CMD_CHAR,       32'h0000_0080, 6'd0);
        send_cmd(CMD_FLUSH,      32'h0000_0000, 6'd0);
        send_cmd(CMD_FLUSH,      32'h0000_0000, 6'd0);
        drain_results();

        // random phases, each under its own widths and idle pattern
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin tx_idle = 1'b0; rx_idle = 1'b0; end
                1: begin tx_idle = 1'b1; rx_idle = 1'b1; end
                2: begin tx_idle = 1'b1; rx_idle = 1'b0; end
                3: begin tx_idle = 1'b0; rx_idle = 1'b1; end
                default: begin
                    tx_idle = $urandom_range(0, 1);
                    rx_idle = $urandom_range(0, 1);
                end
            endcase
            if (p == N_PHASES - 1) begin
                write_all_widths(6'd32, 6'd0, 6'd1, 6'd63);
            end else begin
                write_all_widths(pick_width(), pick_width(), pick_width(), pick_width());
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // in the second phase the sender waits once mid-phase for the block to empty out
                if (p == 1 && n == PHASE_REQUESTS / 2) begin
                    i_in_valid <= 1'b0;
                    do @(negedge i_clk); while (pending != 0);
                    @(posedge i_clk);
                end
                send_request(random_request());
            end
            drain_results();
        end

        $display("covered %0d requests and %0d result bytes under %0d width settings",
                 n_requests, n_results, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("lsb_first_bit_packer test passed");
        end else begin
            $display("lsb_first_bit_packer test failed");
        end
        $finish;
    end

endmodule

// File: lsb_first_bit_packer.f
rtl/lsbp_pkg.sv
rtl/lsbp_cfg.sv
rtl/lsbp_core.sv
rtl/lsb_first_bit_packer.sv
test/lsbp_byte_checker.sv
test/lsb_first_bit_packer_tb.sv
